@@ rtl/core/h2r_pkg.sv @@
package h2r_pkg;

    // Default fixed point format of the inputs
    localparam int FRAC_BITS_DEF = 16;

    // Color channels
    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Largest channel code
    localparam logic [7:0] CHAN_MAX = 8'hFF;

    // Load enables of the five pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

@@ rtl/core/h2r_levels.sv @@
module h2r_levels #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  h2r_pkg::stage_en_t           en,
    input  logic [FRAC_BITS:0]           saturation,
    input  logic [FRAC_BITS:0]           lightness,
    output logic signed [FRAC_BITS+4:0]  lo_level,
    output logic signed [FRAC_BITS+4:0]  delta
);

    localparam int IN_W  = FRAC_BITS + 1;
    localparam int LS_W  = 2 * FRAC_BITS + 2;
    localparam int LVL_W = FRAC_BITS + 5;
    localparam int QW    = LS_W - FRAC_BITS;

    localparam logic [LS_W-1:0] ROUND_UP = {{(LS_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic [IN_W:0]   ONE_X2   = {2'b01, {FRAC_BITS{1'b0}}};

    logic [LS_W-1:0]         ls_reg,   ls_next;
    logic [IN_W-1:0]         l_reg;
    logic [IN_W-1:0]         s_reg;
    logic                    half_reg, half_next;
    logic [LS_W-1:0]         ls_round;
    logic [QW-1:0]           ls_floor;
    logic [QW-1:0]           ls_ceil;
    logic signed [LVL_W-1:0] l_ext;
    logic signed [LVL_W-1:0] s_ext;
    logic signed [LVL_W-1:0] hi_next;
    logic signed [LVL_W-1:0] lo_next;
    logic signed [LVL_W-1:0] lo_reg;
    logic signed [LVL_W-1:0] d_next;
    logic signed [LVL_W-1:0] d_reg;

    // Stage 1: product of lightness and saturation, lightness split at one half
    assign ls_next   = LS_W'(lightness) * LS_W'(saturation);
    assign half_next = ({lightness, 1'b0} <= ONE_X2);

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            ls_reg   <= ls_next;
            l_reg    <= lightness;
            s_reg    <= saturation;
            half_reg <= half_next;
        end
    end

    // Stage 2: upper level floored, lower level and span exact from it
    assign ls_round = ls_reg + ROUND_UP;
    assign ls_floor = ls_reg[LS_W-1:FRAC_BITS];
    assign ls_ceil  = ls_round[LS_W-1:FRAC_BITS];
    assign l_ext    = $signed(LVL_W'(l_reg));
    assign s_ext    = $signed(LVL_W'(s_reg));

    always_comb begin
        if (half_reg) begin
            hi_next = l_ext + $signed(LVL_W'(ls_floor));
        end else begin
            hi_next = l_ext + s_ext - $signed(LVL_W'(ls_ceil));
        end
        lo_next = (l_ext <<< 1) - hi_next;
        d_next  = hi_next - lo_next;
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            lo_reg <= lo_next;
            d_reg  <= d_next;
        end
    end

    assign lo_level = lo_reg;
    assign delta    = d_reg;

endmodule

@@ rtl/core/h2r_hue.sv @@
module h2r_hue #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  h2r_pkg::stage_en_t en,
    input  logic [FRAC_BITS:0] hue,
    output logic [FRAC_BITS:0] ramp_pos [h2r_pkg::NUM_CH]
);

    import h2r_pkg::*;

    localparam int X_W = FRAC_BITS + 5;

    localparam logic signed [X_W-1:0] ONE_X   = {{(X_W-FRAC_BITS-1){1'b0}}, 1'b1,
                                                 {FRAC_BITS{1'b0}}};
    localparam logic signed [X_W-1:0] TWO_X   = ONE_X <<< 1;
    localparam logic signed [X_W-1:0] THREE_X = TWO_X + ONE_X;
    localparam logic signed [X_W-1:0] FOUR_X  = ONE_X <<< 2;
    localparam logic signed [X_W-1:0] SIX_X   = FOUR_X + TWO_X;
    localparam logic [FRAC_BITS:0]    ONE_T   = {1'b1, {FRAC_BITS{1'b0}}};

    logic signed [X_W-1:0] hx;
    logic signed [X_W-1:0] x6;
    logic signed [X_W-1:0] x_next [NUM_CH];
    logic signed [X_W-1:0] x_reg  [NUM_CH];
    logic [FRAC_BITS:0]    t_next [NUM_CH];
    logic [FRAC_BITS:0]    t_reg  [NUM_CH];

    // Stage 1: hue in sixths of a turn, shifted by a third for red and blue
    assign hx = $signed(X_W'(hue));
    assign x6 = (hx <<< 2) + (hx <<< 1);

    assign x_next[CH_RED]   = x6 + TWO_X;
    assign x_next[CH_GREEN] = x6;
    assign x_next[CH_BLUE]  = x6 - TWO_X;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            x_reg <= x_next;
        end
    end

    // Stage 2: wrap once, then pick the ramp weight of the piece
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic signed [X_W-1:0] x_up;
        logic signed [X_W-1:0] x_wrap;
        logic signed [X_W-1:0] x_fall;

        always_comb begin
            x_up   = x_reg[c][X_W-1] ? x_reg[c] + SIX_X : x_reg[c];
            x_wrap = (x_up > SIX_X) ? x_up - SIX_X : x_up;
            x_fall = FOUR_X - x_wrap;
            priority if (x_wrap < ONE_X) begin
                t_next[c] = x_wrap[FRAC_BITS:0];
            end else if (x_wrap < THREE_X) begin
                t_next[c] = ONE_T;
            end else if (x_wrap < FOUR_X) begin
                t_next[c] = x_fall[FRAC_BITS:0];
            end else begin
                t_next[c] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            t_reg <= t_next;
        end
    end

    assign ramp_pos = t_reg;

endmodule

@@ rtl/core/h2r_ramp.sv @@
module h2r_ramp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  h2r_pkg::stage_en_t          en,
    input  logic signed [FRAC_BITS+4:0] lo_level,
    input  logic signed [FRAC_BITS+4:0] delta,
    input  logic [FRAC_BITS:0]          ramp_pos,
    output logic [7:0]                  chan
);

    import h2r_pkg::*;

    localparam int LVL_W  = FRAC_BITS + 5;
    localparam int PROD_W = LVL_W + FRAC_BITS + 2;
    localparam int NUM_W  = PROD_W + 1;
    localparam int MAG_W  = NUM_W - 1;
    localparam int SC_W   = MAG_W + 8;
    localparam int Q_W    = SC_W - 2 * FRAC_BITS;

    logic signed [FRAC_BITS+1:0] t_s;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [LVL_W-1:0]     lo_reg;
    logic signed [NUM_W-1:0]     num_next;
    logic signed [NUM_W-1:0]     num_reg;
    logic [MAG_W-1:0]            mag;
    logic [SC_W-1:0]             scaled;
    logic [Q_W-1:0]              quot;
    logic [7:0]                  chan_next;
    logic [7:0]                  chan_reg;

    // Stage 3: span times ramp weight
    assign t_s       = $signed({1'b0, ramp_pos});
    assign prod_next = PROD_W'(delta) * PROD_W'(t_s);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            prod_reg <= prod_next;
            lo_reg   <= lo_level;
        end
    end

    // Stage 4: add the lower level at full precision
    assign num_next = (NUM_W'(lo_reg) <<< FRAC_BITS) + NUM_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            num_reg <= num_next;
        end
    end

    // Stage 5: scale by 255, truncate, clamp to the 8-bit range
    assign mag    = num_reg[MAG_W-1:0];
    assign scaled = (SC_W'(mag) << 8) - SC_W'(mag);
    assign quot   = scaled[SC_W-1:2*FRAC_BITS];

    always_comb begin
        if (num_reg[NUM_W-1] || (num_reg == '0)) begin
            chan_next = '0;
        end else if (quot > Q_W'(CHAN_MAX)) begin
            chan_next = CHAN_MAX;
        end else begin
            chan_next = quot[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

@@ rtl/core/hsl_to_rgb_converter.sv @@
// HSL to RGB converter, five register stages, one pixel per clock.
// An accepted beat is registered in stages one to five in turn; m_valid is the valid bit of stage five.
// Throughput: one beat per cycle; a stall holds the occupied stages while bubbles fill up.
// The slowest stages are the two multipliers (lightness times saturation, span times ramp).
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers keep no reset.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FRAC_BITS:0] s_hue,
    input  logic [FRAC_BITS:0] s_saturation,
    input  logic [FRAC_BITS:0] s_lightness,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_red,
    output logic [7:0]         m_green,
    output logic [7:0]         m_blue
);

    import h2r_pkg::*;

    localparam int LVL_W = FRAC_BITS + 5;

    stage_en_t               en;
    logic [4:0]              vld_reg;
    logic signed [LVL_W-1:0] lo_level;
    logic signed [LVL_W-1:0] delta;
    logic [FRAC_BITS:0]      ramp_pos [NUM_CH];
    logic [7:0]              chan     [NUM_CH];

    // Advance a stage when it is empty or the stage after it advances
    assign en.s5 = !vld_reg[4] || m_ready;
    assign en.s4 = !vld_reg[3] || en.s5;
    assign en.s3 = !vld_reg[2] || en.s4;
    assign en.s2 = !vld_reg[1] || en.s3;
    assign en.s1 = !vld_reg[0] || en.s2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en.s1) vld_reg[0] <= s_valid;
            if (en.s2) vld_reg[1] <= vld_reg[0];
            if (en.s3) vld_reg[2] <= vld_reg[1];
            if (en.s4) vld_reg[3] <= vld_reg[2];
            if (en.s5) vld_reg[4] <= vld_reg[3];
        end
    end

    assign s_ready = en.s1;
    assign m_valid = vld_reg[4];

    h2r_levels #(
        .FRAC_BITS (FRAC_BITS)
    ) u_levels (
        .aclk       (aclk),
        .en         (en),
        .saturation (s_saturation),
        .lightness  (s_lightness),
        .lo_level   (lo_level),
        .delta      (delta)
    );

    h2r_hue #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hue (
        .aclk     (aclk),
        .en       (en),
        .hue      (s_hue),
        .ramp_pos (ramp_pos)
    );

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ramp
        h2r_ramp #(
            .FRAC_BITS (FRAC_BITS)
        ) u_ramp (
            .aclk     (aclk),
            .en       (en),
            .lo_level (lo_level),
            .delta    (delta),
            .ramp_pos (ramp_pos[c]),
            .chan     (chan[c])
        );
    end

    assign m_red   = chan[CH_RED];
    assign m_green = chan[CH_GREEN];
    assign m_blue  = chan[CH_BLUE];

`ifndef SYNTHESIS
    // A ready sink drains the whole pipe, so the input is never held off
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    // With no output stall an accepted beat reaches m_valid without being held in any stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid)
        else $error("result beat missing after pipeline latency");

    // Zero lightness gives black
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_lightness == '0))
        ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> (m_red == '0) && (m_green == '0) && (m_blue == '0))
        else $error("zero lightness did not give black");

    // Zero saturation gives equal channels
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_saturation == '0))
        ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> (m_red == m_green) && (m_green == m_blue))
        else $error("zero saturation did not give grey");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import h2r_pkg::*;

    localparam int     FB         = FRAC_BITS_DEF;
    localparam longint ONE        = longint'(1) << FB;
    localparam int     CYCLE_CAP  = 200000;
    localparam int     SETTLE     = 20;
    localparam int     PRINT_CAP  = 100;

    typedef logic [FB:0] fx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    fx_t  s_hue;
    fx_t  s_saturation;
    fx_t  s_lightness;
    logic m_valid;
    logic m_ready;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;

    rgb_t pending_rgb[$];
    int   mismatch_count;
    int   cycle_count;
    bit   tx_idle;
    bit   rx_idle;
    int   hold_cycles;

    hsl_to_rgb_converter #(
        .FRAC_BITS(FB)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .s_saturation(s_saturation),
        .s_lightness (s_lightness),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue)
    );

    // Clock: 4 ns period
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Ramp level of one channel at position x, in sixths of a turn
    function automatic logic [7:0] ramp_level(longint lo, longint hi, longint x);
        longint turn;
        longint span;
        longint num;
        longint scaled;
        turn = 6 * ONE;
        span = hi - lo;
        // Wrap once only; anything still out of range lands on the low piece
        if (x < 0) x += turn;
        if (x > turn) x -= turn;
        if (x < ONE)
            num = lo * ONE + span * x;
        else if (x < 3 * ONE)
            num = hi * ONE;
        else if (x < 4 * ONE)
            num = lo * ONE + span * (4 * ONE - x);
        else
            num = lo * ONE;
        if (num <= 0)
            return 8'd0;
        scaled = (num * 255) >> (2 * FB);
        if (scaled > longint'(CHAN_MAX))
            return CHAN_MAX;
        return scaled[7:0];
    endfunction

    // Expected color of one pixel
    function automatic rgb_t predict_rgb(fx_t hue, fx_t sat, fx_t light);
        longint h;
        longint s;
        longint l;
        longint hi;
        longint lo;
        longint x;
        rgb_t   c;
        h = longint'(hue);
        s = longint'(sat);
        l = longint'(light);
        // Helper levels split at lightness one half; hi floors
        if (2 * l <= ONE)
            hi = (l * (ONE + s)) >>> FB;
        else
            hi = ((l + s) * ONE - l * s) >>> FB;
        lo = 2 * l - hi;
        x = 6 * h;
        c.red   = ramp_level(lo, hi, x + 2 * ONE);
        c.green = ramp_level(lo, hi, x);
        c.blue  = ramp_level(lo, hi, x - 2 * ONE);
        return c;
    endfunction

    // Count a mismatch; keep the log short once many have piled up
    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Record accepted pixels, then check each result beat against the oldest one
    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_rgb.push_back(predict_rgb(s_hue, s_saturation, s_lightness));
            if (m_valid && m_ready) begin
                if (pending_rgb.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected (%0d %0d %0d)",
                                              m_red, m_green, m_blue));
                end else begin
                    want = pending_rgb.pop_front();
                    if (m_red !== want.red)
                        report_mismatch($sformatf("red got %0d expected %0d",
                                                  m_red, want.red));
                    if (m_green !== want.green)
                        report_mismatch($sformatf("green got %0d expected %0d",
                                                  m_green, want.green));
                    if (m_blue !== want.blue)
                        report_mismatch($sformatf("blue got %0d expected %0d",
                                                  m_blue, want.blue));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: long hold-off on request, random stall bursts while rx_idle is set, ready otherwise
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                repeat (hold_cycles - 1) @(negedge aclk);
                hold_cycles = 0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Offer one pixel and hold it until accepted; entered and left at a falling edge
    task automatic send_pixel(fx_t hue, fx_t sat, fx_t light);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_hue        = hue;
        s_saturation = sat;
        s_lightness  = light;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Mostly in-range values, some exact corners, some above 1.0
    function automatic fx_t rand_fx();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return fx_t'($urandom_range(0, int'(ONE)));
        if (pick == 7)
            return ($urandom_range(0, 1) != 0) ? fx_t'(ONE) : fx_t'(0);
        return fx_t'($urandom_range(0, (1 << (FB + 1)) - 1));
    endfunction

    // Corners: primaries, sextant borders, lightness split, wrap, clamp at both ends
    task automatic test_directed();
        send_pixel(0, 0, 0);
        send_pixel(0, 0, 65536);
        send_pixel(0, 65536, 32768);
        send_pixel(10923, 65536, 32768);
        send_pixel(21845, 65536, 32768);
        send_pixel(21846, 65536, 32768);
        send_pixel(32768, 65536, 32768);
        send_pixel(43691, 65536, 32768);
        send_pixel(54613, 65536, 32768);
        send_pixel(65536, 65536, 32768);
        send_pixel(98304, 65536, 49152);
        send_pixel(131071, 65536, 32768);
        send_pixel(0, 65536, 32769);
        send_pixel(0, 131071, 16384);
        send_pixel(0, 0, 131071);
        send_pixel(0, 131071, 65536);
        send_pixel(43690, 32768, 98304);
        send_pixel(131071, 131071, 131071);
        send_pixel(1, 1, 1);
        send_pixel(65535, 65535, 65535);
    endtask

    // Random pixels with idling on both sides
    task automatic test_random(int count);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (count) send_pixel(rand_fx(), rand_fx(), rand_fx());
    endtask

    // Hold the result side off while pixels keep coming so the pipeline fills
    task automatic test_backpressure(int count);
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_cycles = 200;
        @(negedge aclk);
        repeat (count) send_pixel(rand_fx(), rand_fx(), rand_fx());
    endtask

    // Back-to-back pixels, no idling
    task automatic test_streaming(int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (count) send_pixel(rand_fx(), rand_fx(), rand_fx());
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_hue          = '0;
        s_saturation   = '0;
        s_lightness    = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        hold_cycles    = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random(540);
        test_backpressure(40);
        test_streaming(60);
        s_valid = 1'b0;

        // Drain, then give the pipeline time to show any stray beat
        while (pending_rgb.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ hsl_to_rgb_converter.f @@
rtl/core/h2r_pkg.sv
rtl/core/h2r_levels.sv
rtl/core/h2r_hue.sv
rtl/core/h2r_ramp.sv
rtl/core/hsl_to_rgb_converter.sv
tb/testbench.sv
